[rtl/lqs_pkg.sv]
package lqs_pkg;

    localparam int WORD_W = 32;
    localparam int OCC_W  = 4;

    localparam logic [1:0] K_ENQ = 2'd0;
    localparam logic [1:0] K_DEQ = 2'd1;
    localparam logic [1:0] K_SRCH = 2'd2;
    localparam logic [1:0] K_UPD = 2'd3;

    localparam logic [1:0] ST_OK        = 2'd0;
    localparam logic [1:0] ST_FULL      = 2'd1;
    localparam logic [1:0] ST_EMPTY     = 2'd2;
    localparam logic [1:0] ST_NOT_FOUND = 2'd3;

    typedef struct packed {
        logic [1:0]               status;
        logic signed [WORD_W-1:0] removed_value;
        logic                     found;
        logic [OCC_W-1:0]         occupancy;
    } res_t;

endpackage

[rtl/lqs_if.sv]
interface lqs_req_if
    import lqs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               kind;
    logic signed [WORD_W-1:0] item_value;
    logic signed [WORD_W-1:0] replacement;

    modport source (output valid, kind, item_value, replacement, input ready);
    modport sink (input valid, kind, item_value, replacement, output ready);
endinterface

interface lqs_rsp_if
    import lqs_pkg::*;
();
    logic                     valid;
    logic                     ready;
    logic [1:0]               status;
    logic signed [WORD_W-1:0] removed_value;
    logic                     found;
    logic [OCC_W-1:0]         occupancy;

    modport source (output valid, status, removed_value, found, occupancy, input ready);
    modport sink (input valid, status, removed_value, found, occupancy, output ready);
endinterface

[rtl/linear_queue_with_search_unit.sv]
// Enqueue and full/empty rejects go from idle straight to S_RESULT, where the
// result is moved into the output register; dequeue first does one synchronous
// read of the entry memory (S_DEQ); search/update first compares k entries
// (1..DEPTH) in S_SCAN, one read per cycle. One item at a time: a result held in
// the output register delays the next item's result, and that waiting item blocks the input.
// Reset clears indices, count and output valid; entry memory is not cleared.
module linear_queue_with_search_unit
    import lqs_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic      clk,
    input  logic      rst_n,
    lqs_req_if.sink   req,
    lqs_rsp_if.source rsp
);

    logic                     mem_wr_en;
    logic [$clog2(DEPTH)-1:0] mem_wr_addr;
    logic [WORD_W-1:0]        mem_wr_data;
    logic                     mem_rd_en;
    logic [$clog2(DEPTH)-1:0] mem_rd_addr;
    logic [WORD_W-1:0]        mem_rd_data;

    lqs_ctrl #(.DEPTH(DEPTH)) u_ctrl (
        .clk         (clk),
        .rst_n       (rst_n),
        .req         (req),
        .rsp         (rsp),
        .mem_wr_en   (mem_wr_en),
        .mem_wr_addr (mem_wr_addr),
        .mem_wr_data (mem_wr_data),
        .mem_rd_en   (mem_rd_en),
        .mem_rd_addr (mem_rd_addr),
        .mem_rd_data (mem_rd_data)
    );

    lqs_mem #(.DEPTH(DEPTH)) u_mem (
        .clk     (clk),
        .wr_en   (mem_wr_en),
        .wr_addr (mem_wr_addr),
        .wr_data (mem_wr_data),
        .rd_en   (mem_rd_en),
        .rd_addr (mem_rd_addr),
        .rd_data (mem_rd_data)
    );

    a_found_ok: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.found |-> rsp.status == ST_OK)
        else $error("found with non-ok status");

    a_reject_clean: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status != ST_OK |-> rsp.removed_value == '0 && !rsp.found)
        else $error("rejected item carries data");

    a_empty_occ: assert property (@(posedge clk) disable iff (!rst_n)
        rsp.valid && rsp.status == ST_EMPTY |-> rsp.occupancy == '0)
        else $error("empty status with nonzero occupancy");

    a_busy_after_accept: assert property (@(posedge clk) disable iff (!rst_n)
        req.valid && req.ready |=> !req.ready)
        else $error("item taken back to back");

endmodule

[rtl/lqs_mem.sv]
module lqs_mem
    import lqs_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       wr_en,
    input  logic [$clog2(DEPTH)-1:0]   wr_addr,
    input  logic [WORD_W-1:0]          wr_data,
    input  logic                       rd_en,
    input  logic [$clog2(DEPTH)-1:0]   rd_addr,
    output logic [WORD_W-1:0]          rd_data
);

    logic [WORD_W-1:0] store_reg [DEPTH];
    logic [WORD_W-1:0] rd_data_reg;

    always_ff @(posedge clk)
    begin
        if (wr_en)
        begin
            store_reg[wr_addr] <= wr_data;
        end
        if (rd_en)
        begin
            rd_data_reg <= store_reg[rd_addr];
        end
    end

    assign rd_data = rd_data_reg;

endmodule

[rtl/lqs_ctrl.sv]
module lqs_ctrl
    import lqs_pkg::*;
#(
    parameter int DEPTH = 8
) (
    input  logic                       clk,
    input  logic                       rst_n,
    lqs_req_if.sink                    req,
    lqs_rsp_if.source                  rsp,
    output logic                       mem_wr_en,
    output logic [$clog2(DEPTH)-1:0]   mem_wr_addr,
    output logic [WORD_W-1:0]          mem_wr_data,
    output logic                       mem_rd_en,
    output logic [$clog2(DEPTH)-1:0]   mem_rd_addr,
    input  logic [WORD_W-1:0]          mem_rd_data
);

    localparam int ADDR_W = $clog2(DEPTH);
    localparam int IDX_W  = $clog2(DEPTH + 1);
    localparam logic [IDX_W-1:0] DEPTH_I = IDX_W'(DEPTH);
    localparam logic [IDX_W-1:0] ONE_I   = IDX_W'(1);

    typedef enum logic [1:0] {S_IDLE, S_DEQ, S_SCAN, S_RESULT} state_t;

    state_t              state_reg, state_next;
    logic [IDX_W-1:0]    head_reg, head_next;
    logic [IDX_W-1:0]    tail_reg, tail_next;
    logic [IDX_W-1:0]    count_reg, count_next;
    logic [IDX_W-1:0]    scan_pos_reg, scan_pos_next;
    logic [ADDR_W-1:0]   cmp_pos_reg, cmp_pos_next;
    logic [WORD_W-1:0]   key_reg, key_next;
    logic [WORD_W-1:0]   repl_reg, repl_next;
    logic                upd_reg, upd_next;
    res_t                res_reg, res_next;
    res_t                out_reg, out_next;
    logic                out_valid_reg, out_valid_next;
    logic                accept;

    assign req.ready = (state_reg == S_IDLE);
    assign accept    = req.valid && req.ready;

    always_comb
    begin
        state_next     = state_reg;
        head_next      = head_reg;
        tail_next      = tail_reg;
        count_next     = count_reg;
        scan_pos_next  = scan_pos_reg;
        cmp_pos_next   = cmp_pos_reg;
        key_next       = key_reg;
        repl_next      = repl_reg;
        upd_next       = upd_reg;
        res_next       = res_reg;
        out_next       = out_reg;
        out_valid_next = out_valid_reg;
        mem_wr_en      = 1'b0;
        mem_wr_addr    = tail_reg[ADDR_W-1:0];
        mem_wr_data    = req.item_value;
        mem_rd_en      = 1'b0;
        mem_rd_addr    = head_reg[ADDR_W-1:0];

        if (out_valid_reg && rsp.ready)
        begin
            out_valid_next = 1'b0;
        end

        unique case (state_reg)
            S_IDLE:
            begin
                if (accept)
                begin
                    key_next   = req.item_value;
                    repl_next  = req.replacement;
                    upd_next   = (req.kind == K_UPD);
                    res_next   = '0;
                    state_next = S_RESULT;
                    if (req.kind == K_ENQ)
                    begin
                        if (tail_reg >= DEPTH_I)
                        begin
                            res_next.status    = ST_FULL;
                            res_next.occupancy = OCC_W'(count_reg);
                        end
                        else
                        begin
                            mem_wr_en          = 1'b1;
                            tail_next          = tail_reg + ONE_I;
                            count_next         = count_reg + ONE_I;
                            res_next.status    = ST_OK;
                            res_next.occupancy = OCC_W'(count_reg + ONE_I);
                        end
                    end
                    else if (count_reg == '0)
                    begin
                        res_next.status = ST_EMPTY;
                    end
                    else if (req.kind == K_DEQ)
                    begin
                        mem_rd_en  = 1'b1;
                        state_next = S_DEQ;
                    end
                    else
                    begin
                        // first compare reads the head entry
                        mem_rd_en     = 1'b1;
                        cmp_pos_next  = head_reg[ADDR_W-1:0];
                        scan_pos_next = head_reg + ONE_I;
                        state_next    = S_SCAN;
                    end
                end
            end
            S_DEQ:
            begin
                res_next               = '0;
                res_next.status        = ST_OK;
                res_next.removed_value = mem_rd_data;
                res_next.occupancy     = OCC_W'(count_reg - ONE_I);
                count_next             = count_reg - ONE_I;
                if (count_reg == ONE_I)
                begin
                    // drained: reclaim the whole array
                    head_next = '0;
                    tail_next = '0;
                end
                else
                begin
                    head_next = head_reg + ONE_I;
                end
                state_next = S_RESULT;
            end
            S_SCAN:
            begin
                // one read in flight; data of cmp_pos arrives this cycle
                if (mem_rd_data == key_reg)
                begin
                    mem_wr_en          = upd_reg;
                    mem_wr_addr        = cmp_pos_reg;
                    mem_wr_data        = repl_reg;
                    res_next           = '0;
                    res_next.status    = ST_OK;
                    res_next.found     = 1'b1;
                    res_next.occupancy = OCC_W'(count_reg);
                    state_next         = S_RESULT;
                end
                else if (scan_pos_reg < tail_reg)
                begin
                    mem_rd_en     = 1'b1;
                    mem_rd_addr   = scan_pos_reg[ADDR_W-1:0];
                    cmp_pos_next  = scan_pos_reg[ADDR_W-1:0];
                    scan_pos_next = scan_pos_reg + ONE_I;
                end
                else
                begin
                    res_next           = '0;
                    res_next.status    = ST_NOT_FOUND;
                    res_next.occupancy = OCC_W'(count_reg);
                    state_next         = S_RESULT;
                end
            end
            S_RESULT:
            begin
                if (!out_valid_reg || rsp.ready)
                begin
                    out_next       = res_reg;
                    out_valid_next = 1'b1;
                    state_next     = S_IDLE;
                end
            end
            default:
            begin
                state_next = S_IDLE;
            end
        endcase
    end

    always_ff @(posedge clk or negedge rst_n)
    begin
        if (!rst_n)
        begin
            state_reg     <= S_IDLE;
            head_reg      <= '0;
            tail_reg      <= '0;
            count_reg     <= '0;
            out_valid_reg <= 1'b0;
        end
        else
        begin
            state_reg     <= state_next;
            head_reg      <= head_next;
            tail_reg      <= tail_next;
            count_reg     <= count_next;
            out_valid_reg <= out_valid_next;
        end
    end

    always_ff @(posedge clk)
    begin
        scan_pos_reg <= scan_pos_next;
        cmp_pos_reg  <= cmp_pos_next;
        key_reg      <= key_next;
        repl_reg     <= repl_next;
        upd_reg      <= upd_next;
        res_reg      <= res_next;
        out_reg      <= out_next;
    end

    assign rsp.valid         = out_valid_reg;
    assign rsp.status        = out_reg.status;
    assign rsp.removed_value = out_reg.removed_value;
    assign rsp.found         = out_reg.found;
    assign rsp.occupancy     = out_reg.occupancy;

endmodule
